### hdl/dlmbr_pkg.sv
package dlmbr_pkg;

  // Fixed field and arithmetic widths of the layer engine.
  localparam int DATA_BITS = 16;
  localparam int FRAC_BITS = 8;
  localparam int ACC_BITS  = 40;
  localparam int PROD_BITS = 2 * DATA_BITS;

  localparam int MODE_W    = 2;
  localparam int ROW_W     = 8;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 9;
  localparam int IN_DIM_W  = 9;
  localparam int OUT_DIM_W = 7;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_IN_DIM  = 2'd0;
  localparam logic [1:0] CFG_OUT_DIM = 2'd1;
  localparam logic [1:0] CFG_RELU    = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_WEIGHT = 2'd0,
    MODE_BIAS   = 2'd1,
    MODE_ACT    = 2'd2
  } mode_e;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic mul_en;    // weight read data is valid, form the product
    logic acc_en;    // product is valid, add it into the accumulator
    logic acc_last;  // that product closes the row
    logic fin;       // apply bias, shift, ReLU and saturation
    logic relu;      // clamp negative results to zero
    logic shift;     // move results one cell towards the output
  } cell_ctl_t;

endpackage

### hdl/dlmbr_ram.sv
module dlmbr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### hdl/dlmbr_cell.sv
module dlmbr_cell import dlmbr_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        w_we_i,
  input  logic [AW-1:0]               w_addr_i,
  input  logic [DATA_BITS-1:0]        w_data_i,
  input  logic [AW-1:0]               r_addr_i,
  input  logic                        b_we_i,
  input  logic signed [DATA_BITS-1:0] act_i,
  input  cell_ctl_t                   ctl_i,
  input  logic [DATA_BITS-1:0]        shift_i,
  output logic [DATA_BITS-1:0]        res_o
);

  localparam int SH_W = ACC_BITS - FRAC_BITS;
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((1 << (DATA_BITS - 1)) - 1);
  localparam logic signed [SH_W-1:0] SAT_LO = -SAT_HI - SH_W'(1);

  logic [DATA_BITS-1:0]        w_rd;
  logic signed [PROD_BITS-1:0] prod_q;
  logic signed [ACC_BITS-1:0]  acc_q, acc_d, sum_q, acc_sum, biased;
  logic signed [DATA_BITS-1:0] bias_q;
  logic signed [SH_W-1:0]      shifted;
  logic [DATA_BITS-1:0]        res_q, res_d;

  // This cell's column of the weight matrix.
  dlmbr_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_wram (
    .clk_i   (clk_i),
    .we_i    (w_we_i),
    .waddr_i (w_addr_i),
    .wdata_i (w_data_i),
    .raddr_i (r_addr_i),
    .rdata_o (w_rd)
  );

  always_comb begin
    acc_sum = acc_q + {{(ACC_BITS - PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};
    acc_d   = acc_q;
    if (ctl_i.acc_en) begin
      acc_d = ctl_i.acc_last ? '0 : acc_sum;
    end
  end

  // The bias is scaled to the accumulator's Q24.16; dropping the low fraction bits floors.
  always_comb begin
    biased  = sum_q + {{(ACC_BITS - DATA_BITS - FRAC_BITS){bias_q[DATA_BITS-1]}},
                       bias_q, {FRAC_BITS{1'b0}}};
    shifted = biased[ACC_BITS-1:FRAC_BITS];
    priority if (ctl_i.relu && shifted < 0) begin
      res_d = '0;
    end else if (shifted > SAT_HI) begin
      res_d = SAT_HI[DATA_BITS-1:0];
    end else if (shifted < SAT_LO) begin
      res_d = SAT_LO[DATA_BITS-1:0];
    end else begin
      res_d = shifted[DATA_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= act_i * $signed(w_rd);
    end
    if (ctl_i.acc_en && ctl_i.acc_last) begin
      sum_q <= acc_sum;
    end
    if (b_we_i) begin
      bias_q <= w_data_i;
    end
    if (ctl_i.fin) begin
      res_q <= res_d;
    end else if (ctl_i.shift) begin
      res_q <= shift_i;
    end
  end

  assign res_o = res_q;

endmodule

### hdl/dense_layer_matmul_bias_relu.sv
// Fully connected layer engine in signed Q8.8: a chain of MAX_OUT identical cells, one per
// output neuron, each holding its own column of weights in a small RAM, its bias and a
// 40-bit accumulator. Load items (weight or bias) and row elements are taken at one transfer
// per clock cycle while the input is not stalled. A row element is broadcast to every cell,
// which reads its weight for the current inner index, multiplies and accumulates over a
// three-stage pipeline (RAM read, multiply, add). Once the element that completes the row
// has been taken, the input stalls: the row sum is registered, then each cell adds its bias,
// floors away the low fraction bits, applies ReLU when enabled and saturates to 16 bits,
// and the results then shift along the chain towards cell 0, one result transfer per cycle
// while out_ready_i is high, in neuron order, with out_last_o on the final one.
// The drain runs along the cell chain's shift path. Weight and bias entries must be written
// before they are used; an unwritten entry returns arbitrary data. There is no clearing pass
// after reset. Configuration writes must only be made while no row is being drained.
module dense_layer_matmul_bias_relu import dlmbr_pkg::*; #(
  parameter int MAX_IN  = 256,
  parameter int MAX_OUT = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port.
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [IN_DIM_W-1:0]         cfg_wdata_i,
  // Input item channel.
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [MODE_W-1:0]           mode_i,
  input  logic [ROW_W-1:0]            weight_row_i,
  input  logic [IDX_W-1:0]            neuron_index_i,
  input  logic signed [DATA_BITS-1:0] value_i,
  // Result channel.
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DATA_BITS-1:0] out_value_o,
  output logic [IDX_W-1:0]            out_index_o,
  output logic                        out_last_o
);

  localparam int AW    = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
  localparam int CMP_W = 11;

  // Configuration registers.
  logic [IN_DIM_W-1:0]  in_dim_q;
  logic [OUT_DIM_W-1:0] out_dim_q;
  logic                 relu_q;

  // Sequencer state.
  logic [CNT_W-1:0]            elem_cnt_q, cnt_inc;
  logic                        busy_q;
  logic signed [DATA_BITS-1:0] act_q;
  logic                        st1_vld_q, st1_last_q, st2_vld_q, st2_last_q, fin_q;
  logic                        out_vld_q;
  logic [IDX_W-1:0]            out_cnt_q, last_idx;

  logic             in_xfer, out_xfer;
  logic             wload, bload, act_take, row_end;
  logic [CMP_W-1:0] eff_in;
  logic [AW-1:0]    rd_addr;
  cell_ctl_t        ctl;

  logic [DATA_BITS-1:0] res   [MAX_OUT];
  logic [DATA_BITS-1:0] shin  [MAX_OUT];

  assign in_ready_o = !busy_q;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_vld_q && out_ready_i;

  // Decode of the accepted item. Unknown modes are taken and dropped.
  always_comb begin
    wload    = 1'b0;
    bload    = 1'b0;
    act_take = 1'b0;
    unique case (mode_e'(mode_i))
      MODE_WEIGHT: wload    = in_xfer
                              && (CMP_W'(weight_row_i) < CMP_W'(MAX_IN))
                              && (OUT_DIM_W'(neuron_index_i) < OUT_DIM_W'(MAX_OUT));
      MODE_BIAS:   bload    = in_xfer && (OUT_DIM_W'(neuron_index_i) < OUT_DIM_W'(MAX_OUT));
      MODE_ACT:    act_take = in_xfer;
      default:     ;
    endcase
  end

  // Dimensions outside their legal range are clamped to it.
  always_comb begin
    if (in_dim_q == '0) begin
      eff_in = CMP_W'(1);
    end else if (CMP_W'(in_dim_q) > CMP_W'(MAX_IN)) begin
      eff_in = CMP_W'(MAX_IN);
    end else begin
      eff_in = CMP_W'(in_dim_q);
    end
    if (out_dim_q == '0) begin
      last_idx = '0;
    end else if (out_dim_q > OUT_DIM_W'(MAX_OUT)) begin
      last_idx = IDX_W'(MAX_OUT - 1);
    end else begin
      last_idx = IDX_W'(out_dim_q - OUT_DIM_W'(1));
    end
  end

  // The row ends when the count reaches or passes the row length, or has wrapped.
  assign cnt_inc = elem_cnt_q + CNT_W'(1);
  assign row_end = (cnt_inc == '0) || (CMP_W'(cnt_inc) >= eff_in);

  // A count beyond the weight store reads its last inner index.
  assign rd_addr = (CMP_W'(elem_cnt_q) >= CMP_W'(MAX_IN)) ? AW'(MAX_IN - 1)
                                                          : AW'(elem_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_dim_q  <= IN_DIM_W'(256);
      out_dim_q <= OUT_DIM_W'(64);
      relu_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IN_DIM:  in_dim_q  <= cfg_wdata_i;
        CFG_OUT_DIM: out_dim_q <= cfg_wdata_i[OUT_DIM_W-1:0];
        CFG_RELU:    relu_q    <= cfg_wdata_i[0];
        default:     ;
      endcase
    end
  end

  // Sequencer: element count, pipeline tags and the result drain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_cnt_q <= '0;
      busy_q     <= 1'b0;
      st1_vld_q  <= 1'b0;
      st1_last_q <= 1'b0;
      st2_vld_q  <= 1'b0;
      st2_last_q <= 1'b0;
      fin_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      out_cnt_q  <= '0;
    end else begin
      st1_vld_q  <= act_take;
      st1_last_q <= act_take && row_end;
      st2_vld_q  <= st1_vld_q;
      st2_last_q <= st1_last_q;
      fin_q      <= st2_vld_q && st2_last_q;
      if (act_take) begin
        elem_cnt_q <= row_end ? '0 : cnt_inc;
        if (row_end) begin
          busy_q <= 1'b1;
        end
      end
      if (fin_q) begin
        out_vld_q <= 1'b1;
        out_cnt_q <= '0;
      end else if (out_xfer) begin
        if (out_cnt_q == last_idx) begin
          out_vld_q <= 1'b0;
          busy_q    <= 1'b0;
        end else begin
          out_cnt_q <= out_cnt_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_take) begin
      act_q <= value_i;
    end
  end

  always_comb begin
    ctl.mul_en   = st1_vld_q;
    ctl.acc_en   = st2_vld_q;
    ctl.acc_last = st2_last_q;
    ctl.fin      = fin_q;
    ctl.relu     = relu_q;
    ctl.shift    = out_xfer;
  end

  // The cell chain; results travel towards cell 0, which drives the output.
  for (genvar j = 0; j < MAX_OUT; j++) begin : g_cell
    if (j == MAX_OUT - 1) begin : g_tail
      assign shin[j] = '0;
    end else begin : g_link
      assign shin[j] = res[j+1];
    end

    dlmbr_cell #(
      .DEPTH (MAX_IN),
      .AW    (AW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .w_we_i   (wload && (neuron_index_i == IDX_W'(j))),
      .w_addr_i (AW'(weight_row_i)),
      .w_data_i (value_i),
      .r_addr_i (rd_addr),
      .b_we_i   (bload && (neuron_index_i == IDX_W'(j))),
      .act_i    (act_q),
      .ctl_i    (ctl),
      .shift_i  (shin[j]),
      .res_o    (res[j])
    );
  end

  assign out_valid_o = out_vld_q;
  assign out_value_o = res[0];
  assign out_index_o = out_cnt_q;
  assign out_last_o  = out_cnt_q == last_idx;

  // Results are only drained while the input is held off.
  a_drain_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input accepted while results are being drained");

  // The final result transfer ends the drain and frees the input.
  a_last_ends_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_last_o) |=> (!out_valid_o && in_ready_o))
    else $error("drain did not end after the final result");

  // A drain always starts at neuron 0.
  a_drain_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (out_index_o == '0))
    else $error("drain did not start at neuron 0");

  // Finalisation only happens for a row that has closed and holds the input off.
  a_fin_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> (busy_q && !out_vld_q))
    else $error("finalisation outside a closed row");

endmodule
